>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LFPD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LFPD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/lfpd_pkg.sv
package lfpd_pkg;

   // Sensor array and channel widths.
   localparam int SensorCount   = 8;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 16;
   localparam int ReqDataWidth  = 16;
   localparam int RspDataWidth  = 40;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrBaseSpeed  = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPropGain   = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrDerivGain  = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CsrBrakeSpeed = 8'd3;

   // Register values after reset.
   localparam logic signed [15:0] BaseSpeedReset  = 16'sd0;
   localparam logic signed [15:0] PropGainReset   = 16'sd20;
   localparam logic signed [15:0] DerivGainReset  = 16'sd50;
   localparam logic [14:0]        BrakeSpeedReset = 15'd0;

   // Position weight of each sensor, sensor 0 first.
   localparam logic signed [4:0] SensorWeight [SensorCount] =
      '{-5'sd7, -5'sd4, -5'sd3, -5'sd1, 5'sd1, 5'sd3, 5'sd4, 5'sd7};

   // The multiplier takes one bit of the 5-bit error terms per cycle.
   localparam int               MacSteps    = 5;
   localparam logic [2:0]       MacLastStep = 3'(MacSteps - 1);

   // Result of the position stage.
   typedef struct packed {
      logic              found;
      logic signed [3:0] error;
   } pos_result_type;

   // Operands handed to the steering multiplier.
   typedef struct packed {
      logic signed [3:0]  error;
      logic signed [3:0]  previous;
      logic signed [15:0] prop_gain;
      logic signed [15:0] deriv_gain;
   } mac_request_type;

endpackage

>>> src/line_follow_pd_steering.sv
// Each accepted item goes through the sensor scan, the serial division and the
// bit-serial multiply into the output register; a lost-line item skips division
// and multiply. Items are worked on one at a time, but a new item is taken while
// a finished result still waits in the output register. Reset (synchronous,
// active high) clears the stored error and restores register defaults.
`include "assert_macros.svh"

module line_follow_pd_steering (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] sensor_bits, [8] clear_history, [15:9] zero
   input  logic [lfpd_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] line_found, [16:1] left_drive, [32:17] right_drive,
   // [36:33] position_error, [39:37] zero
   output logic [lfpd_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lfpd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [lfpd_pkg::CsrDataWidth-1:0]    csr_data
);

   localparam logic [1:0] StIdle     = 2'd0;
   localparam logic [1:0] StPosition = 2'd1;
   localparam logic [1:0] StSteer    = 2'd2;
   localparam logic [1:0] StFinish   = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [15:0]                      base_ff, base_in;
   logic [15:0]                      prop_ff, prop_in;
   logic [15:0]                      deriv_ff, deriv_in;
   logic [14:0]                      brake_ff, brake_in;
   logic [3:0]                       prev_ff, prev_in;
   logic                             pend_found_ff, pend_found_in;
   logic [15:0]                      pend_left_ff, pend_left_in;
   logic [15:0]                      pend_right_ff, pend_right_in;
   logic [3:0]                       pend_error_ff, pend_error_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lfpd_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic                             req_accept;
   logic                             rsp_load;
   logic                             pos_done;
   lfpd_pkg::pos_result_type         pos_result;
   logic                             mac_start;
   lfpd_pkg::mac_request_type        mac_request;
   logic                             mac_done;
   logic [15:0]                      turn;
   logic [15:0]                      brake_drive;

   assign req_tready = (state_ff == StIdle);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Position error: sensor scan and serial division.
   lfpd_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .sensor_bits (req_tdata[lfpd_pkg::SensorCount-1:0]),
      .done        (pos_done),
      .result      (pos_result)
   );

   // Steering term: bit-serial multiply-accumulate.
   assign mac_start              = (state_ff == StPosition) && pos_done && pos_result.found;
   assign mac_request.error      = pos_result.error;
   assign mac_request.previous   = prev_ff;
   assign mac_request.prop_gain  = prop_ff;
   assign mac_request.deriv_gain = deriv_ff;

   lfpd_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .request (mac_request),
      .done    (mac_done),
      .turn    (turn)
   );

   // Configuration writes; unknown indexes are dropped.
   always_comb begin
      base_in  = base_ff;
      prop_in  = prop_ff;
      deriv_in = deriv_ff;
      brake_in = brake_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lfpd_pkg::CsrBaseSpeed:  base_in  = csr_data;
            lfpd_pkg::CsrPropGain:   prop_in  = csr_data;
            lfpd_pkg::CsrDerivGain:  deriv_in = csr_data;
            lfpd_pkg::CsrBrakeSpeed: brake_in = csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   assign brake_drive = 16'(16'd0 - {1'b0, brake_ff});
   assign rsp_load    = (state_ff == StFinish) && (!rsp_valid_ff || rsp_tready);

   // Item sequencer and history update.
   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      pend_found_in = pend_found_ff;
      pend_left_in  = pend_left_ff;
      pend_right_in = pend_right_ff;
      pend_error_in = pend_error_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_accept) begin
               if (req_tdata[lfpd_pkg::SensorCount]) begin
                  prev_in = 4'd0;
               end
               state_in = StPosition;
            end
         end
         StPosition: begin
            if (pos_done) begin
               if (pos_result.found) begin
                  // The multiplier has latched the old error this cycle.
                  prev_in       = pos_result.error;
                  pend_found_in = 1'b1;
                  pend_error_in = pos_result.error;
                  state_in      = StSteer;
               end else begin
                  pend_found_in = 1'b0;
                  pend_left_in  = brake_drive;
                  pend_right_in = brake_drive;
                  pend_error_in = 4'd0;
                  state_in      = StFinish;
               end
            end
         end
         StSteer: begin
            if (mac_done) begin
               pend_left_in  = base_ff + turn;
               pend_right_in = base_ff - turn;
               state_in      = StFinish;
            end
         end
         StFinish: begin
            if (rsp_load) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = {3'b000, pend_error_ff, pend_right_ff, pend_left_ff, pend_found_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         base_ff      <= lfpd_pkg::BaseSpeedReset;
         prop_ff      <= lfpd_pkg::PropGainReset;
         deriv_ff     <= lfpd_pkg::DerivGainReset;
         brake_ff     <= lfpd_pkg::BrakeSpeedReset;
         prev_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         prop_ff      <= prop_in;
         deriv_ff     <= deriv_in;
         brake_ff     <= brake_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_found_ff <= pend_found_in;
      pend_left_ff  <= pend_left_in;
      pend_right_ff <= pend_right_in;
      pend_error_ff <= pend_error_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A lost-line result brakes both wheels alike and reports no error.
   `LFPD_ASSERT(a_lost_line_brakes, clock, reset, rsp_valid_ff && !rsp_data_ff[0] |-> rsp_data_ff[36:33] == 4'd0 && rsp_data_ff[16:1] == rsp_data_ff[32:17], "lost-line result is not a plain brake")

   // The stored error moves only while an item is being worked on.
   `LFPD_ASSERT(a_history_quiet_when_idle, clock, reset, state_ff == StIdle && !req_accept |=> $stable(prev_ff), "stored error changed while idle")

   // Reset leaves the sequencer idle with an empty output register.
   `LFPD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == StIdle && !rsp_valid_ff, "block not idle after reset")

endmodule

>>> src/lfpd_pos.sv
module lfpd_pos (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lfpd_pkg::SensorCount-1:0]    sensor_bits,
   output logic                                done,
   output lfpd_pkg::pos_result_type            result
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StScan   = 2'd1;
   localparam logic [1:0] StDivide = 2'd2;
   localparam logic [1:0] StSign   = 2'd3;

   logic [1:0]                         state_ff, state_in;
   logic [lfpd_pkg::SensorCount-1:0]   bits_ff, bits_in;
   logic [2:0]                         step_ff, step_in;
   logic signed [4:0]                  sum_ff, sum_in;
   logic [3:0]                         count_ff, count_in;
   logic [3:0]                         mag_ff, mag_in;
   logic [3:0]                         rem_ff, rem_in;
   logic                               neg_ff, neg_in;

   logic signed [4:0]                  weight;
   logic signed [4:0]                  sum_next;
   logic [3:0]                         count_next;
   logic [4:0]                         rem_shift;
   logic                               quot_bit;

   // Scan one sensor per cycle, then divide one quotient bit per cycle.
   always_comb begin
      state_in = state_ff;
      bits_in  = bits_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;

      weight     = bits_ff[0] ? lfpd_pkg::SensorWeight[step_ff] : 5'sd0;
      sum_next   = sum_ff + weight;
      count_next = count_ff + {3'b000, bits_ff[0]};

      rem_shift = {rem_ff, mag_ff[3]};
      quot_bit  = (rem_shift >= {1'b0, count_ff});

      unique case (state_ff)
         StIdle: begin
            if (start) begin
               bits_in  = sensor_bits;
               step_in  = 3'd0;
               sum_in   = 5'sd0;
               count_in = 4'd0;
               state_in = StScan;
            end
         end
         StScan: begin
            bits_in  = bits_ff >> 1;
            sum_in   = sum_next;
            count_in = count_next;
            step_in  = step_ff + 3'd1;
            if (step_ff == 3'(lfpd_pkg::SensorCount - 1)) begin
               // Divide the magnitude and restore the sign afterwards.
               neg_in   = sum_next[4];
               mag_in   = sum_next[4] ? 4'(-sum_next) : sum_next[3:0];
               rem_in   = 4'd0;
               step_in  = 3'd0;
               state_in = (count_next == 4'd0) ? StSign : StDivide;
            end
         end
         StDivide: begin
            if (quot_bit) begin
               rem_in = 4'(rem_shift - {1'b0, count_ff});
            end else begin
               rem_in = rem_shift[3:0];
            end
            mag_in  = {mag_ff[2:0], quot_bit};
            step_in = step_ff + 3'd1;
            if (step_ff[1:0] == 2'd3) begin
               state_in = StSign;
            end
         end
         StSign: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      bits_ff  <= bits_in;
      step_ff  <= step_in;
      sum_ff   <= sum_in;
      count_ff <= count_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
   end

   // The quotient sits in mag_ff once the division is over.
   always_comb begin
      done         = (state_ff == StSign);
      result.found = (count_ff != 4'd0);
      if (count_ff == 4'd0) begin
         result.error = 4'sd0;
      end else if (neg_ff) begin
         result.error = 4'(4'd0 - mag_ff);
      end else begin
         result.error = mag_ff;
      end
   end

endmodule

>>> src/lfpd_mac.sv
module lfpd_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  lfpd_pkg::mac_request_type  request,
   output logic                       done,
   output logic [15:0]                turn
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StDone = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  mul_p_ff, mul_p_in;
   logic [4:0]  mul_d_ff, mul_d_in;
   logic [15:0] gain_p_ff, gain_p_in;
   logic [15:0] gain_d_ff, gain_d_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  step_ff, step_in;

   logic [15:0] add_p;
   logic [15:0] add_d;

   // Shift-and-add over the multiplier bits; the top bit carries negative weight.
   // Only the low 16 bits of the turn term reach the drives, so the sum wraps.
   always_comb begin
      state_in  = state_ff;
      mul_p_in  = mul_p_ff;
      mul_d_in  = mul_d_ff;
      gain_p_in = gain_p_ff;
      gain_d_in = gain_d_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;

      add_p = mul_p_ff[0] ? gain_p_ff : 16'd0;
      add_d = mul_d_ff[0] ? gain_d_ff : 16'd0;

      unique case (state_ff)
         StIdle: begin
            if (start) begin
               mul_p_in  = {request.error[3], request.error};
               mul_d_in  = 5'({request.error[3], request.error}
                              - {request.previous[3], request.previous});
               gain_p_in = request.prop_gain;
               gain_d_in = request.deriv_gain;
               acc_in    = 16'd0;
               step_in   = 3'd0;
               state_in  = StRun;
            end
         end
         StRun: begin
            if (step_ff == lfpd_pkg::MacLastStep) begin
               acc_in   = acc_ff - add_p - add_d;
               state_in = StDone;
            end else begin
               acc_in = acc_ff + add_p + add_d;
            end
            mul_p_in  = mul_p_ff >> 1;
            mul_d_in  = mul_d_ff >> 1;
            gain_p_in = gain_p_ff << 1;
            gain_d_in = gain_d_ff << 1;
            step_in   = step_ff + 3'd1;
         end
         StDone: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      mul_p_ff  <= mul_p_in;
      mul_d_ff  <= mul_d_in;
      gain_p_ff <= gain_p_in;
      gain_d_ff <= gain_d_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
   end

   assign done = (state_ff == StDone);
   assign turn = acc_ff;

endmodule
